>>> src/mlbd_pkg.sv
// Package: shared widths and the configuration bundle for the mip-level downsampler.
package mlbd_pkg;

  localparam int unsigned PixW   = 8;
  localparam int unsigned PairW  = 9;
  localparam int unsigned WidthW = 12;
  localparam int unsigned HeightW = 13;
  localparam int unsigned TotalW = 23;
  localparam int unsigned EmitW  = 22;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic [WidthW-1:0]  WidthReset  = 12'd256;
  localparam logic [HeightW-1:0] HeightReset = 13'd256;

  // register indexes (taken from paddr[2])
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  // geometry handed from the register block to the datapath
  typedef struct packed {
    logic               avg;      // both dimensions even: 2x2 averaging
    logic [WidthW-1:0]  w;        // clamped width
    logic [HeightW-1:0] h;        // clamped height
    logic [TotalW-1:0]  total;    // pixels in the new level
    logic               restart;  // register write: start the image over
  } cfg_t;

endpackage

>>> src/mlbd_line_mem.sv
// Line memory: one horizontal pair sum per entry, registered read port.
module mlbd_line_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [mlbd_pkg::PairW-1:0]  wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [mlbd_pkg::PairW-1:0]  rdata_o
);

  logic [mlbd_pkg::PairW-1:0] mem [Depth];
  logic [mlbd_pkg::PairW-1:0] rdata_q;

  // write the pair sum of an even row
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read the sum above; hold it until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/mlbd_cfg.sv
// Register block: APB-style width and height registers, clamping and level size.
module mlbd_cfg #(
  parameter int unsigned MaxWidth  = 2048,
  parameter int unsigned MaxHeight = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mlbd_pkg::AddrW-1:0]   paddr,
  input  logic [mlbd_pkg::DataW-1:0]   pwdata,
  output logic [mlbd_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output mlbd_pkg::cfg_t               cfg_o
);

  logic [mlbd_pkg::WidthW-1:0]  width_q, width_d;
  logic [mlbd_pkg::HeightW-1:0] height_q, height_d;
  logic                         wr_en;
  logic [mlbd_pkg::WidthW-1:0]  w_c;
  logic [mlbd_pkg::HeightW-1:0] h_c;
  logic [mlbd_pkg::WidthW-2:0]  nw;
  logic [mlbd_pkg::HeightW-2:0] nh;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // decode the write
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      case (paddr[2])
        mlbd_pkg::RegWidth:  width_d  = pwdata[mlbd_pkg::WidthW-1:0];
        mlbd_pkg::RegHeight: height_d = pwdata[mlbd_pkg::HeightW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mlbd_pkg::WidthReset;
      height_q <= mlbd_pkg::HeightReset;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // read back the raw register
  always_comb begin
    case (paddr[2])
      mlbd_pkg::RegWidth:  prdata = mlbd_pkg::DataW'(width_q);
      mlbd_pkg::RegHeight: prdata = mlbd_pkg::DataW'(height_q);
      default:             prdata = '0;
    endcase
  end

  // clamp to one and to the maximum size
  always_comb begin
    if (width_q == '0) begin
      w_c = mlbd_pkg::WidthW'(1);
    end else if (32'(width_q) > 32'(MaxWidth)) begin
      w_c = mlbd_pkg::WidthW'(MaxWidth);
    end else begin
      w_c = width_q;
    end
    if (height_q == '0) begin
      h_c = mlbd_pkg::HeightW'(1);
    end else if (32'(height_q) > 32'(MaxHeight)) begin
      h_c = mlbd_pkg::HeightW'(MaxHeight);
    end else begin
      h_c = height_q;
    end
  end

  // halve with a floor of one
  assign nw = (w_c[mlbd_pkg::WidthW-1:1] == '0) ? (mlbd_pkg::WidthW-1)'(1)
                                                : w_c[mlbd_pkg::WidthW-1:1];
  assign nh = (h_c[mlbd_pkg::HeightW-1:1] == '0) ? (mlbd_pkg::HeightW-1)'(1)
                                                 : h_c[mlbd_pkg::HeightW-1:1];

  assign cfg_o.avg     = !w_c[0] && !h_c[0];
  assign cfg_o.w       = w_c;
  assign cfg_o.h       = h_c;
  assign cfg_o.total   = mlbd_pkg::TotalW'(nw) * mlbd_pkg::TotalW'(nh);
  assign cfg_o.restart = wr_en;

endmodule

>>> src/mip_level_box_downsample_core.sv
// Top level: raster counters, line-memory pipeline and output register.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------
//   in      | in        | in_valid_i/in_ready_o | pixel_in_i
//   out     | out       | out_valid_o/out_ready_i | pixel_out_o, last_out_o
//   cfg     | in        | psel/penable/pready   | paddr, pwdata, prdata
//
// One pixel is accepted per clock while in_ready_o is high. The result of the
// pixel that completes it is registered in the line-memory read stage, then in
// the output register. Reset clears counters and valid flags; the line memory
// is not cleared, an odd row only reads sums that the even row above it wrote.
// A stalled output holds one result and one more in the read stage, after
// which in_ready_o drops.
module mip_level_box_downsample_core #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mlbd_pkg::PixW-1:0]    pixel_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mlbd_pkg::PixW-1:0]    pixel_out_o,
  output logic                         last_out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mlbd_pkg::AddrW-1:0]   paddr,
  input  logic [mlbd_pkg::DataW-1:0]   pwdata,
  output logic [mlbd_pkg::DataW-1:0]   prdata,
  output logic                         pready
);

  localparam int unsigned LineDepth = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
  localparam int unsigned LineAW    = (LineDepth > 1) ? $clog2(LineDepth) : 1;

  mlbd_pkg::cfg_t cfg;

  logic [mlbd_pkg::WidthW-1:0]  col_q, col_d;
  logic [mlbd_pkg::HeightW-1:0] row_q, row_d;
  logic [mlbd_pkg::EmitW-1:0]   emitted_q, emitted_d;
  logic [mlbd_pkg::PixW-1:0]    left_q, left_d;

  logic                         s1_valid_q, s1_valid_d;
  logic                         s1_avg_q, s1_avg_d;
  logic [mlbd_pkg::PairW-1:0]   s1_data_q, s1_data_d;
  logic                         s1_last_q, s1_last_d;

  logic                         out_valid_q;
  logic [mlbd_pkg::PixW-1:0]    out_pixel_q;
  logic                         out_last_q;

  logic                         in_acc;
  logic                         s1_adv;
  logic                         emit;
  logic [mlbd_pkg::PairW-1:0]   pair;
  logic [LineAW-1:0]            line_addr;
  logic                         mem_we;
  logic                         mem_re;
  logic [mlbd_pkg::PairW-1:0]   above;
  logic [mlbd_pkg::PixW-1:0]    avg_pix;
  logic                         is_last;
  logic [mlbd_pkg::WidthW-1:0]  col_inc;
  logic [mlbd_pkg::HeightW-1:0] row_inc;

  mlbd_cfg #(
    .MaxWidth  (MAX_WIDTH),
    .MaxHeight (MAX_HEIGHT)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // the write of an even row and the read of the row below are a row apart
  mlbd_line_mem #(
    .Depth (LineDepth),
    .AW    (LineAW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (line_addr),
    .wdata_i (pair),
    .re_i    (mem_re),
    .raddr_i (line_addr),
    .rdata_o (above)
  );

  // handshake: the read stage moves on when the output register frees up
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  assign pair      = mlbd_pkg::PairW'(left_q) + mlbd_pkg::PairW'(pixel_in_i);
  assign line_addr = LineAW'(col_q >> 1);
  assign mem_we    = in_acc && cfg.avg && col_q[0] && !row_q[0];
  assign mem_re    = in_acc && cfg.avg && col_q[0] && row_q[0];
  assign emit      = cfg.avg ? (col_q[0] && row_q[0])
                             : (mlbd_pkg::TotalW'(emitted_q) < cfg.total);
  assign is_last   = (mlbd_pkg::TotalW'(emitted_q) + mlbd_pkg::TotalW'(1)) == cfg.total;
  assign col_inc   = col_q + mlbd_pkg::WidthW'(1);
  assign row_inc   = row_q + mlbd_pkg::HeightW'(1);

  // advance the raster position and load the read stage
  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    emitted_d  = emitted_q;
    left_d     = left_q;
    s1_valid_d = s1_valid_q && !s1_adv;
    s1_avg_d   = s1_avg_q;
    s1_data_d  = s1_data_q;
    s1_last_d  = s1_last_q;
    if (in_acc) begin
      if (cfg.avg && !col_q[0]) begin
        left_d = pixel_in_i;
      end
      if (emit) begin
        s1_valid_d = 1'b1;
        s1_avg_d   = cfg.avg;
        s1_data_d  = cfg.avg ? pair : mlbd_pkg::PairW'(pixel_in_i);
        s1_last_d  = is_last;
        emitted_d  = emitted_q + mlbd_pkg::EmitW'(1);
      end
      col_d = col_inc;
      if (col_inc >= cfg.w) begin
        col_d = '0;
        row_d = row_inc;
        if (row_inc >= cfg.h) begin
          row_d     = '0;
          emitted_d = '0;
        end
      end
    end
    if (cfg.restart) begin
      col_d     = '0;
      row_d     = '0;
      emitted_d = '0;
      left_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      emitted_q  <= '0;
      left_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      emitted_q  <= emitted_d;
      left_q     <= left_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_avg_q  <= s1_avg_d;
    s1_data_q <= s1_data_d;
    s1_last_q <= s1_last_d;
  end

  // add the sum above and drop the two low bits
  assign avg_pix = mlbd_pkg::PixW'((10'(above) + 10'(s1_data_q)) >> 2);

  // hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_pixel_q <= s1_avg_q ? avg_pix : s1_data_q[mlbd_pkg::PixW-1:0];
      out_last_q  <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_pixel_q;
  assign last_out_o  = out_last_q;

  // both stages full and stalled: no item may enter
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("item accepted while both stages are full");

  // line reads only in averaging mode on odd rows, never with a write
  a_read_odd_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> (cfg.avg && row_q[0] && !mem_we))
    else $error("line memory read outside an odd row");

  // results given never exceed the size of the new level
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mlbd_pkg::TotalW'(emitted_q) <= cfg.total)
    else $error("emitted count beyond level size");

  // a waiting read-stage result moves to the output when it frees up
  a_s1_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_adv) |=> out_valid_q)
    else $error("read-stage result lost");

endmodule
